// ===== hdl/ncm_pkg.sv =====
// Package for the necklace counter: widths, payload types, unit request and
// response structs, and the state enums of the sequencers.
// No dependencies.
`timescale 1ns / 1ps

package ncm_pkg;

    localparam int VALUE_BITS = 30;
    localparam int ROOT_BITS  = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS    = VALUE_BITS + 2;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

    typedef logic [VALUE_BITS-1:0] word_t;

    localparam word_t MODULUS_RESET = VALUE_BITS'(1000000007);

    // operand pair for the serial divider and the modular multiplier
    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } op_req_t;

    typedef struct packed {
        logic  done;
        word_t q;
        word_t r;
    } div_rsp_t;

    typedef struct packed {
        logic  done;
        word_t res;
    } unit_rsp_t;

    typedef struct packed {
        logic  start;
        word_t base;
        word_t expo;
    } pow_req_t;

    typedef struct packed {
        logic  start;
        word_t x;
    } tot_req_t;

    typedef enum logic [2:0] {
        PW_IDLE,
        PW_BASE,
        PW_LOOP,
        PW_MUL,
        PW_SQR,
        PW_DONE
    } pow_state_t;

    typedef enum logic [3:0] {
        TT_IDLE,
        TT_TEST,
        TT_STRIP,
        TT_DIVW,
        TT_ACC,
        TT_ACCW,
        TT_NEXT,
        TT_LAST,
        TT_LASTW,
        TT_MOD,
        TT_MODW,
        TT_DONE
    } tot_state_t;

    typedef enum logic [3:0] {
        TP_IDLE,
        TP_LOOP,
        TP_DIVW,
        TP_P,
        TP_W,
        TP_M,
        TP_MW,
        TP_NEXT,
        TP_FIN
    } top_state_t;

endpackage

// ===== hdl/ncm_if.sv =====
// Valid/ready channel interfaces for the necklace counter.
// Depends on ncm_pkg.
`timescale 1ns / 1ps

interface ncm_in_if;
    import ncm_pkg::*;
    logic  valid;
    logic  ready;
    word_t value_n;

    modport source (output valid, output value_n, input ready);
    modport sink   (input valid, input value_n, output ready);
endinterface

interface ncm_out_if;
    import ncm_pkg::*;
    logic  valid;
    logic  ready;
    word_t necklace_count;

    modport source (output valid, output necklace_count, input ready);
    modport sink   (input valid, input necklace_count, output ready);
endinterface

// ===== hdl/necklace_count_mod.sv =====
// Necklace counter top level: divisor sequencer, modulus register, output register.
// Depends on ncm_pkg, ncm_if, ncm_div, ncm_mulmod, ncm_pow, ncm_tot.
//
//   port      dir   handshake       payload
//   in_ch     sink  valid / ready   value_n        (30 b)
//   out_ch    src   valid / ready   necklace_count (30 b)
//   cfg       in    cfg_we          cfg_wdata      (modulus, 30 b)
//
// Each candidate i with i*i < n costs mostly one serial divide; each divisor pair
// adds two power/totient runs (in parallel) and two modmuls. A power's cost grows
// with its exponent bits and set bits, a totient's with its trial candidates up
// to sqrt(x), all set by the bit-serial divider and multiplier. One item at a time.
// Reset loads modulus 1000000007; no clearing pass. in_ch is ready whenever the
// sequencer is idle; a finished count waits in the output register under stall.
`timescale 1ns / 1ps

module necklace_count_mod (
    input  logic              clk,
    input  logic              rst_n,
    ncm_in_if.sink            in_ch,
    ncm_out_if.source         out_ch,
    input  logic              cfg_we,
    input  ncm_pkg::word_t    cfg_wdata
);
    import ncm_pkg::*;

    top_state_t           state_reg, state_next;
    word_t                modulus_reg;
    word_t                n_reg, n_next;
    logic [ROOT_BITS-1:0] i_reg, i_next;
    logic [SQ_BITS-1:0]   sq_reg, sq_next;
    word_t                q_reg, q_next;
    word_t                total_reg, total_next;
    word_t                pw_reg, pw_next;
    word_t                tt_reg, tt_next;
    logic                 pw_got_reg, pw_got_next;
    logic                 tt_got_reg, tt_got_next;
    logic                 phase_b_reg, phase_b_next;
    logic                 sq_case_reg, sq_case_next;
    logic                 out_valid_reg, out_valid_next;
    word_t                count_reg, count_next;
    logic [VALUE_BITS:0]  sum;
    word_t                sum_red;
    op_req_t              div_req, mm_req;
    div_rsp_t             div_rsp;
    unit_rsp_t            mm_rsp, pow_rsp, tot_rsp;
    pow_req_t             pow_req;
    tot_req_t             tot_req;

    ncm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ncm_mulmod u_mm (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    ncm_pow u_pow (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (pow_req),
        .rsp     (pow_rsp)
    );

    ncm_tot u_tot (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (tot_req),
        .rsp     (tot_rsp)
    );

    always_comb
    begin
        sum     = {1'b0, total_reg} + {1'b0, mm_rsp.res};
        sum_red = (sum >= {1'b0, modulus_reg}) ? VALUE_BITS'(sum - {1'b0, modulus_reg})
                                               : sum[VALUE_BITS-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        sq_next        = sq_reg;
        q_next         = q_reg;
        total_next     = total_reg;
        pw_next        = pw_reg;
        tt_next        = tt_reg;
        pw_got_next    = pw_got_reg;
        tt_got_next    = tt_got_reg;
        phase_b_next   = phase_b_reg;
        sq_case_next   = sq_case_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        div_req        = '0;
        mm_req         = '0;
        pow_req        = '0;
        tot_req        = '0;
        in_ch.ready    = 1'b0;
        unique case (state_reg)
            TP_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    n_next       = in_ch.value_n;
                    total_next   = '0;
                    i_next       = ROOT_BITS'(1);
                    sq_next      = SQ_BITS'(1);
                    sq_case_next = 1'b0;
                    if (modulus_reg < word_t'(2))
                        state_next = TP_FIN;
                    else
                        state_next = TP_LOOP;
                end
            end
            TP_LOOP:
            begin
                if (sq_reg < SQ_BITS'(n_reg))
                begin
                    div_req.start = 1'b1;
                    div_req.a     = n_reg;
                    div_req.b     = word_t'(i_reg);
                    state_next    = TP_DIVW;
                end
                else if (n_reg != '0 && sq_reg == SQ_BITS'(n_reg))
                begin
                    // square root divisor, counted once
                    q_next       = word_t'(i_reg);
                    sq_case_next = 1'b1;
                    phase_b_next = 1'b0;
                    state_next   = TP_P;
                end
                else
                    state_next = TP_FIN;
            end
            TP_DIVW:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.r == '0)
                    begin
                        q_next       = div_rsp.q;
                        phase_b_next = 1'b0;
                        state_next   = TP_P;
                    end
                    else
                        state_next = TP_NEXT;
                end
            end
            TP_P:
            begin
                pow_req.start = 1'b1;
                pow_req.base  = n_reg;
                pow_req.expo  = phase_b_reg ? q_reg - 1'b1 : word_t'(i_reg) - 1'b1;
                tot_req.start = 1'b1;
                tot_req.x     = phase_b_reg ? word_t'(i_reg) : q_reg;
                pw_got_next   = 1'b0;
                tt_got_next   = 1'b0;
                state_next    = TP_W;
            end
            TP_W:
            begin
                if (pow_rsp.done)
                begin
                    pw_next     = pow_rsp.res;
                    pw_got_next = 1'b1;
                end
                if (tot_rsp.done)
                begin
                    tt_next     = tot_rsp.res;
                    tt_got_next = 1'b1;
                end
                if ((pw_got_reg || pow_rsp.done) && (tt_got_reg || tot_rsp.done))
                    state_next = TP_M;
            end
            TP_M:
            begin
                mm_req.start = 1'b1;
                mm_req.a     = pw_reg;
                mm_req.b     = tt_reg;
                state_next   = TP_MW;
            end
            TP_MW:
            begin
                if (mm_rsp.done)
                begin
                    total_next = sum_red;
                    if (sq_case_reg)
                        state_next = TP_FIN;
                    else if (!phase_b_reg)
                    begin
                        phase_b_next = 1'b1;
                        state_next   = TP_P;
                    end
                    else
                        state_next = TP_NEXT;
                end
            end
            TP_NEXT:
            begin
                i_next     = i_reg + 1'b1;
                sq_next    = sq_reg + (SQ_BITS'(i_reg) << 1) + SQ_BITS'(1);
                state_next = TP_LOOP;
            end
            TP_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    count_next     = total_reg;
                    out_valid_next = 1'b1;
                    state_next     = TP_IDLE;
                end
            end
            default:
                state_next = TP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TP_IDLE;
            modulus_reg   <= MODULUS_RESET;
            out_valid_reg <= 1'b0;
            pw_got_reg    <= 1'b0;
            tt_got_reg    <= 1'b0;
            phase_b_reg   <= 1'b0;
            sq_case_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pw_got_reg    <= pw_got_next;
            tt_got_reg    <= tt_got_next;
            phase_b_reg   <= phase_b_next;
            sq_case_reg   <= sq_case_next;
            if (cfg_we)
                modulus_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        sq_reg    <= sq_next;
        q_reg     <= q_next;
        total_reg <= total_next;
        pw_reg    <= pw_next;
        tt_reg    <= tt_next;
        count_reg <= count_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.necklace_count = count_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> state_reg != TP_IDLE)
        else $error("sequencer stayed idle after an input transfer");

    a_total_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == TP_MW && mm_rsp.done |=> total_reg < modulus_reg)
        else $error("running total not reduced below modulus");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == TP_FIN)
        else $error("result raised outside the finish state");

endmodule

// ===== hdl/ncm_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ncm_pkg.
`timescale 1ns / 1ps

module ncm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ncm_pkg::op_req_t  req,
    output ncm_pkg::div_rsp_t rsp
);
    import ncm_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    word_t               quo_reg, quo_next;
    word_t               rem_reg, rem_next;
    word_t               dvs_reg, dvs_next;
    logic [VALUE_BITS:0] trial;
    logic                ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.a;
            rem_next  = '0;
            dvs_next  = req.b;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? VALUE_BITS'(trial - {1'b0, dvs_reg}) : trial[VALUE_BITS-1:0];
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = quo_reg;
    assign rsp.r    = rem_reg;

endmodule

// ===== hdl/ncm_mulmod.sv =====
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// operands must already be below the modulus. Depends on ncm_pkg.
`timescale 1ns / 1ps

module ncm_mulmod (
    input  logic               clk,
    input  logic               rst_n,
    input  ncm_pkg::word_t     modulus,
    input  ncm_pkg::op_req_t   req,
    output ncm_pkg::unit_rsp_t rsp
);
    import ncm_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    word_t               acc_reg, acc_next;
    word_t               ma_reg, ma_next;
    word_t               mb_reg, mb_next;
    word_t               mod_reg, mod_next;
    logic [VALUE_BITS:0] dbl, dbl_red, sum, sum_red;

    always_comb
    begin
        dbl       = {acc_reg, 1'b0};
        dbl_red   = (dbl >= {1'b0, mod_reg}) ? dbl - {1'b0, mod_reg} : dbl;
        sum       = dbl_red + (mb_reg[VALUE_BITS-1] ? {1'b0, ma_reg} : '0);
        sum_red   = (sum >= {1'b0, mod_reg}) ? sum - {1'b0, mod_reg} : sum;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        mod_next  = mod_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            ma_next   = req.a;
            mb_next   = req.b;
            mod_next  = modulus;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red[VALUE_BITS-1:0];
            mb_next  = {mb_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        mod_reg <= mod_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule

// ===== hdl/ncm_pow.sv =====
// Modular power by square and multiply over the serial multiplier.
// Depends on ncm_pkg, ncm_div, ncm_mulmod.
`timescale 1ns / 1ps

module ncm_pow (
    input  logic               clk,
    input  logic               rst_n,
    input  ncm_pkg::word_t     modulus,
    input  ncm_pkg::pow_req_t  req,
    output ncm_pkg::unit_rsp_t rsp
);
    import ncm_pkg::*;

    pow_state_t state_reg, state_next;
    word_t      base_reg, base_next;
    word_t      acc_reg, acc_next;
    word_t      expo_reg, expo_next;
    op_req_t    div_req, mm_req;
    div_rsp_t   div_rsp;
    unit_rsp_t  mm_rsp;

    ncm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ncm_mulmod u_mm (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        expo_next  = expo_reg;
        div_req    = '0;
        mm_req     = '0;
        rsp.done   = 1'b0;
        rsp.res    = acc_reg;
        unique case (state_reg)
            PW_IDLE:
            begin
                if (req.start)
                begin
                    div_req.start = 1'b1;
                    div_req.a     = req.base;
                    div_req.b     = modulus;
                    expo_next     = req.expo;
                    state_next    = PW_BASE;
                end
            end
            PW_BASE:
            begin
                if (div_rsp.done)
                begin
                    base_next  = div_rsp.r;
                    acc_next   = word_t'(1);
                    state_next = PW_LOOP;
                end
            end
            PW_LOOP:
            begin
                if (expo_reg == '0)
                    state_next = PW_DONE;
                else if (expo_reg[0])
                begin
                    mm_req.start = 1'b1;
                    mm_req.a     = acc_reg;
                    mm_req.b     = base_reg;
                    state_next   = PW_MUL;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    mm_req.a     = base_reg;
                    mm_req.b     = base_reg;
                    state_next   = PW_SQR;
                end
            end
            PW_MUL:
            begin
                if (mm_rsp.done)
                begin
                    acc_next     = mm_rsp.res;
                    mm_req.start = 1'b1;
                    mm_req.a     = base_reg;
                    mm_req.b     = base_reg;
                    state_next   = PW_SQR;
                end
            end
            PW_SQR:
            begin
                if (mm_rsp.done)
                begin
                    base_next  = mm_rsp.res;
                    expo_next  = expo_reg >> 1;
                    state_next = PW_LOOP;
                end
            end
            PW_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = PW_IDLE;
            end
            default:
                state_next = PW_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PW_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        acc_reg  <= acc_next;
        expo_reg <= expo_next;
    end

endmodule

// ===== hdl/ncm_tot.sv =====
// Euler totient by trial division over the serial divider, result reduced
// by the modulus. Depends on ncm_pkg, ncm_div.
`timescale 1ns / 1ps

module ncm_tot (
    input  logic               clk,
    input  logic               rst_n,
    input  ncm_pkg::word_t     modulus,
    input  ncm_pkg::tot_req_t  req,
    output ncm_pkg::unit_rsp_t rsp
);
    import ncm_pkg::*;

    tot_state_t           state_reg, state_next;
    word_t                x_reg, x_next;
    word_t                acc_reg, acc_next;
    word_t                res_reg, res_next;
    logic [ROOT_BITS-1:0] p_reg, p_next;
    logic [SQ_BITS-1:0]   pp_reg, pp_next;
    logic                 found_reg, found_next;
    op_req_t              div_req;
    div_rsp_t             div_rsp;

    ncm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        p_next     = p_reg;
        pp_next    = pp_reg;
        found_next = found_reg;
        div_req    = '0;
        rsp.done   = 1'b0;
        rsp.res    = res_reg;
        unique case (state_reg)
            TT_IDLE:
            begin
                if (req.start)
                begin
                    x_next     = req.x;
                    acc_next   = req.x;
                    p_next     = ROOT_BITS'(2);
                    pp_next    = SQ_BITS'(4);
                    found_next = 1'b0;
                    state_next = TT_TEST;
                end
            end
            TT_TEST:
            begin
                if (pp_reg > SQ_BITS'(x_reg))
                    state_next = TT_LAST;
                else
                begin
                    div_req.start = 1'b1;
                    div_req.a     = x_reg;
                    div_req.b     = word_t'(p_reg);
                    state_next    = TT_DIVW;
                end
            end
            TT_STRIP:
            begin
                div_req.start = 1'b1;
                div_req.a     = x_reg;
                div_req.b     = word_t'(p_reg);
                state_next    = TT_DIVW;
            end
            TT_DIVW:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.r == '0)
                    begin
                        x_next     = div_rsp.q;
                        found_next = 1'b1;
                        state_next = TT_STRIP;
                    end
                    else if (found_reg)
                        state_next = TT_ACC;
                    else
                        state_next = TT_NEXT;
                end
            end
            TT_ACC:
            begin
                div_req.start = 1'b1;
                div_req.a     = acc_reg;
                div_req.b     = word_t'(p_reg);
                state_next    = TT_ACCW;
            end
            TT_ACCW:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = acc_reg - div_rsp.q;
                    state_next = TT_NEXT;
                end
            end
            TT_NEXT:
            begin
                p_next     = p_reg + 1'b1;
                pp_next    = pp_reg + (SQ_BITS'(p_reg) << 1) + SQ_BITS'(1);
                found_next = 1'b0;
                state_next = TT_TEST;
            end
            TT_LAST:
            begin
                // leftover prime factor above the square root
                if (x_reg > word_t'(1))
                begin
                    div_req.start = 1'b1;
                    div_req.a     = acc_reg;
                    div_req.b     = x_reg;
                    state_next    = TT_LASTW;
                end
                else
                    state_next = TT_MOD;
            end
            TT_LASTW:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = acc_reg - div_rsp.q;
                    state_next = TT_MOD;
                end
            end
            TT_MOD:
            begin
                div_req.start = 1'b1;
                div_req.a     = acc_reg;
                div_req.b     = modulus;
                state_next    = TT_MODW;
            end
            TT_MODW:
            begin
                if (div_rsp.done)
                begin
                    res_next   = div_rsp.r;
                    state_next = TT_DONE;
                end
            end
            TT_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = TT_IDLE;
            end
            default:
                state_next = TT_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TT_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        p_reg   <= p_next;
        pp_reg  <= pp_next;
    end

endmodule

// ===== test/necklace_count_mod_tb.sv =====
// Testbench for necklace_count_mod: drives value_n transfers, predicts each
// necklace count and checks the results in order. Depends on ncm_pkg, ncm_if.
`timescale 1ns / 1ps

module necklace_count_mod_tb;
    import ncm_pkg::*;

    class necklace_board;
        longint unsigned modulus;
        word_t           counts_due[$];
        int              errors;
        int              checked;

        function new();
            modulus = MODULUS_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                          longint unsigned m);
            longint unsigned acc;
            acc = 1 % m;
            b = b % m;
            while (e != 0)
            begin
                if (e[0])
                    acc = (acc * b) % m;
                b = (b * b) % m;
                e = e >> 1;
            end
            return acc;
        endfunction

        function longint unsigned phi_mod(longint unsigned x, longint unsigned m);
            longint unsigned acc;
            longint unsigned p;
            acc = x;
            for (p = 2; p * p <= x; p++)
            begin
                if (x % p == 0)
                begin
                    while (x % p == 0)
                        x = x / p;
                    acc = acc - acc / p;
                end
            end
            if (x > 1)
                acc = acc - acc / x;
            return acc % m;
        endfunction

        function word_t necklaces(word_t value_n);
            longint unsigned n;
            longint unsigned m;
            longint unsigned total;
            longint unsigned i;
            n = value_n;
            m = modulus;
            total = 0;
            if (m < 2)
                return '0;
            for (i = 1; i * i < n; i++)
            begin
                if (n % i == 0)
                begin
                    total = (total + (pow_mod(n, i - 1, m) * phi_mod(n / i, m)) % m
                             + (pow_mod(n, n / i - 1, m) * phi_mod(i, m)) % m) % m;
                end
            end
            if (n != 0 && i * i == n)
                total = (total + (pow_mod(n, i - 1, m) * phi_mod(i, m)) % m) % m;
            return word_t'(total);
        endfunction

        function void note_input(word_t value_n);
            counts_due.push_back(necklaces(value_n));
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_count(word_t got);
            word_t want;
            if (counts_due.size() == 0)
            begin
                report($sformatf("unexpected count %0d", got));
                return;
            end
            want = counts_due.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("necklace_count %0d, expected %0d", got, want));
        endtask
    endclass

    localparam int LIMIT = 20_000_000;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    word_t cfg_wdata;

    ncm_in_if  in_if ();
    ncm_out_if out_if ();

    necklace_count_mod dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    necklace_board board;
    bit      quiet;
    int      hold_req;
    int      cycles;
    int      sent;
    int      sink_stall;
    int      sink_run;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n <= 0;
        cfg_we <= 0;
        cfg_wdata <= '0;
        in_if.valid <= 0;
        in_if.value_n <= '0;
        out_if.ready <= 0;
    end

    // transfer monitor: sample before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
                board.note_input(in_if.value_n);
            if (out_if.valid && out_if.ready)
                board.check_count(out_if.necklace_count);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold on request
    initial
    begin
        sink_stall = 0;
        sink_run = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                out_if.ready <= 0;
                hold_req--;
            end
            else if (quiet)
                out_if.ready <= 1;
            else if (sink_stall > 0)
            begin
                out_if.ready <= 0;
                sink_stall--;
            end
            else if (sink_run > 0)
            begin
                out_if.ready <= 1;
                sink_run--;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                sink_stall = $urandom_range(1, 12) - 1;
                out_if.ready <= 0;
            end
            else
            begin
                sink_run = $urandom_range(0, 20);
                out_if.ready <= 1;
            end
        end
    end

    task send_item(input word_t n);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_if.valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_if.valid <= 1;
        in_if.value_n <= n;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        sent++;
    endtask

    // one edge first so the monitor has noted the last transfer
    task drain;
        in_if.valid <= 0;
        @(posedge clk);
        while (board.counts_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task write_modulus(input word_t m);
        cfg_we <= 1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 0;
        board.modulus = m;
        @(posedge clk);
    endtask

    // mostly small n keeps the divisor scan short
    function word_t pick_n();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return word_t'($urandom_range(0, 300));
        else if (r < 9)
            return word_t'($urandom_range(0, 5000));
        else
            return word_t'($urandom_range(0, 65535));
    endfunction

    task random_phase(input int count);
        repeat (count) send_item(pick_n());
    endtask

    initial
    begin
        word_t directed [$];
        board = new();
        quiet = 0;
        hold_req = 0;
        cycles = 0;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset modulus; zero beads, squares, primes, all-ones extreme
        directed = '{0, 1, 2, 3, 4, 6, 9, 12, 36, 97, 100, 720, 1024, 4093,
                     30'h3FFF_FFFF};
        foreach (directed[k])
            send_item(directed[k]);
        drain();

        write_modulus(word_t'(2));
        send_item(word_t'(0));
        send_item(word_t'(5));
        random_phase(12);
        drain();

        write_modulus(30'h3FFF_FFFF);
        send_item(word_t'(1));
        send_item(word_t'(48));
        random_phase(12);
        // input stalls while the count waits in the output register
        hold_req = 20000;
        quiet = 1;
        random_phase(4);
        quiet = 0;
        drain();

        // moduli below two force a zero count
        write_modulus(word_t'(0));
        send_item(word_t'(6));
        random_phase(5);
        drain();
        write_modulus(word_t'(1));
        send_item(word_t'(7));
        random_phase(5);
        drain();

        write_modulus(word_t'($urandom_range(2, 1000)));
        random_phase(20);
        drain();

        write_modulus(word_t'($urandom_range(2, 30'h3FFF_FFFF)));
        random_phase(10);
        quiet = 1;
        random_phase(15);
        drain();

        $display("%0d value_n transfers, %0d counts checked over 7 modulus settings",
                 sent, board.checked);
        $display("covered zero beads, moduli 0, 1, 2, reset and maximum, long output stall");
        if (board.errors == 0 && board.counts_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
